// ----- rtl/ds_twr_range_filter_core_macros.svh -----
// Assertion macros used by the checker file
`ifndef DS_TWR_RANGE_FILTER_CORE_MACROS_SVH
`define DS_TWR_RANGE_FILTER_CORE_MACROS_SVH
// implication checked every clock outside reset
`define DTRF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbl failed");
// next-cycle implication
`define DTRF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbl failed");
`endif

// ----- rtl/dtrf_pkg.sv -----
// Package: widths, constants, command/status types for the ranging filter
`timescale 1ns / 1ps
package dtrf_pkg;
  localparam int TS_W = 32;
  localparam int TOF_W = 40;
  localparam int DIST_W = 48;
  localparam int THR_W = 40;
  localparam int LIM_W = 8;
  localparam int CNT_W = 4;
  localparam int SUM_W = 52;
  localparam int NUM_W = 64;
  localparam int DEN_W = 34;
  localparam int WINDOW_SIZE_DEF = 10;
  localparam logic [TS_W-1:0] MPT_RST = 32'd20144771;
  localparam logic [THR_W-1:0] THR_RST = 40'd1310720;
  localparam logic [LIM_W-1:0] LIM_RST = 8'd20;
  localparam logic [1:0] REG_MPT = 2'd0;
  localparam logic [1:0] REG_THR = 2'd1;
  localparam logic [1:0] REG_LIM = 2'd2;

  typedef struct packed {
    logic load;     // capture timestamps, form intervals
    logic prod;     // form products and denominator
    logic div_init; // set up the division
    logic div_step; // one restoring division step
    logic tof;      // saturate quotient
    logic mul_hi;   // tmag * hi
    logic mul_lo;   // tmag * lo, build distance
    logic filt;     // filter decision, window update
    logic mdiv_init; // start mean division
    logic mdiv_step; // one mean division step
    logic fin;      // form result item
  } dtrf_cmd_t;

  typedef struct packed {
    logic need_mean; // result needs window mean
  } dtrf_sts_t;
endpackage

// ----- rtl/dtrf_ctrl.sv -----
// Sequencer for the ranging datapath
`timescale 1ns / 1ps
module dtrf_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  dtrf_pkg::dtrf_sts_t sts,
  output dtrf_pkg::dtrf_cmd_t cmd
);
  import dtrf_pkg::*;
  typedef enum logic [3:0] {
    S_IDLE, S_PROD, S_DINIT, S_DIV, S_TOF, S_MHI, S_MLO, S_FILT, S_MINIT, S_MDIV, S_FIN, S_OUT
  } state_t;
  state_t state_r;
  logic [6:0] cnt_r;
  logic out_valid_r;

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    cmd.load = (state_r == S_IDLE) && in_valid;
    cmd.prod = (state_r == S_PROD);
    cmd.div_init = (state_r == S_DINIT);
    cmd.div_step = (state_r == S_DIV);
    cmd.tof = (state_r == S_TOF);
    cmd.mul_hi = (state_r == S_MHI);
    cmd.mul_lo = (state_r == S_MLO);
    cmd.filt = (state_r == S_FILT);
    cmd.mdiv_init = (state_r == S_MINIT);
    cmd.mdiv_step = (state_r == S_MDIV);
    cmd.fin = (state_r == S_FIN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (in_valid) state_r <= S_PROD;
        S_PROD: state_r <= S_DINIT;
        S_DINIT: begin
          state_r <= S_DIV;
          cnt_r <= 7'(NUM_W - 1);
        end
        S_DIV: begin
          if (cnt_r == '0) state_r <= S_TOF;
          else cnt_r <= cnt_r - 7'd1;
        end
        S_TOF: state_r <= S_MHI;
        S_MHI: state_r <= S_MLO;
        S_MLO: state_r <= S_FILT;
        S_FILT: state_r <= S_MINIT;
        S_MINIT: begin
          if (sts.need_mean) begin
            state_r <= S_MDIV;
            cnt_r <= 7'(SUM_W - 1);
          end else begin
            state_r <= S_FIN;
          end
        end
        S_MDIV: begin
          if (cnt_r == '0) state_r <= S_FIN;
          else cnt_r <= cnt_r - 7'd1;
        end
        S_FIN: begin
          state_r <= S_OUT;
          out_valid_r <= 1'b1;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/dtrf_datapath.sv -----
// Datapath: intervals, flight-time division, scaling and window filter
`timescale 1ns / 1ps
module dtrf_datapath #(
  parameter int WINDOW_SIZE = dtrf_pkg::WINDOW_SIZE_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  dtrf_pkg::dtrf_cmd_t cmd,
  output dtrf_pkg::dtrf_sts_t sts,
  input  logic [dtrf_pkg::TS_W-1:0] ps, rh, fs, ph, rs, fh,
  input  logic [dtrf_pkg::TS_W-1:0] mpt,
  input  logic [dtrf_pkg::THR_W-1:0] thr,
  input  logic [dtrf_pkg::LIM_W-1:0] lim,
  output logic signed [dtrf_pkg::TOF_W-1:0] flight_ticks,
  output logic signed [dtrf_pkg::DIST_W-1:0] raw_distance,
  output logic signed [dtrf_pkg::DIST_W-1:0] smoothed_distance,
  output logic sample_rejected,
  output logic window_cleared,
  output logic [dtrf_pkg::CNT_W-1:0] window_count,
  output logic bad_denominator
);
  import dtrf_pkg::*;
  localparam int IDX_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int FILL_W = $clog2(WINDOW_SIZE + 1);

  logic [TS_W-1:0] ra_r, da_r, rb_r, db_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic neg_r, bad_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W:0] rem_r;
  logic [TOF_W-1:0] tmag_r;
  logic [TOF_W+16-1:0] phi_r;
  logic [DIST_W-1:0] dmag_r;
  logic signed [DIST_W-1:0] raw_r;

  // window state
  logic signed [DIST_W-1:0] win_r [WINDOW_SIZE];
  logic [IDX_W-1:0] head_r;
  logic [FILL_W-1:0] fill_r;
  logic signed [SUM_W-1:0] total_r;
  logic signed [DIST_W-1:0] last_r;
  logic [LIM_W-1:0] rej_r;
  logic rejected_r, cleared_r;
  logic need_mean_r;
  // mean division on magnitudes
  logic mneg_r;
  logic [SUM_W-1:0] mq_r;
  logic [FILL_W:0] mrem_r;
  logic [FILL_W-1:0] mdiv_r;

  logic [NUM_W-1:0] p1, p2;
  logic [DEN_W:0] trial;
  logic [FILL_W:0] mtrial;
  logic signed [DIST_W:0] diff;
  logic [DIST_W:0] amag;
  logic [IDX_W-1:0] tail_idx;
  logic [IDX_W:0] tail_sum;
  logic [TOF_W+16:0] dsum;
  logic signed [SUM_W-1:0] raw_ext, tot_acc;

  assign p1 = NUM_W'(ra_r) * NUM_W'(rb_r);
  assign p2 = NUM_W'(da_r) * NUM_W'(db_r);
  assign trial = {rem_r[DEN_W-1:0], quo_r[NUM_W-1]} - {1'b0, den_r};
  assign mtrial = {mrem_r[FILL_W-1:0], mq_r[SUM_W-1]} - {1'b0, mdiv_r};
  assign diff = {raw_r[DIST_W-1], raw_r} - {last_r[DIST_W-1], last_r};
  assign amag = diff[DIST_W] ? (DIST_W+1)'(0) - $unsigned(diff) : $unsigned(diff);
  assign tail_sum = {1'b0, head_r} + (IDX_W+1)'(fill_r);
  assign tail_idx = (tail_sum >= (IDX_W+1)'(WINDOW_SIZE)) ?
                    IDX_W'(tail_sum - (IDX_W+1)'(WINDOW_SIZE)) : IDX_W'(tail_sum);
  assign dsum = (TOF_W+17)'(phi_r) +
                (TOF_W+17)'(((TOF_W+16)'(tmag_r) * (TOF_W+16)'(mpt[15:0])) >> 16);
  assign raw_ext = SUM_W'(raw_r);
  assign tot_acc = total_r + raw_ext;

  assign sts.need_mean = need_mean_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      head_r <= '0;
      total_r <= '0;
      last_r <= '0;
      rej_r <= '0;
      need_mean_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        ra_r <= rh - ps;
        da_r <= fs - rh;
        rb_r <= fh - rs;
        db_r <= rs - ph;
      end
      if (cmd.prod) begin
        den_r <= DEN_W'(ra_r) + DEN_W'(rb_r) + DEN_W'(da_r) + DEN_W'(db_r);
        if (p1 >= p2) begin
          num_r <= p1 - p2;
          neg_r <= 1'b0;
        end else begin
          num_r <= p2 - p1;
          neg_r <= 1'b1;
        end
      end
      if (cmd.div_init) begin
        bad_r <= (den_r == '0);
        quo_r <= num_r;
        rem_r <= '0;
      end
      if (cmd.div_step) begin
        if (!trial[DEN_W]) begin
          rem_r <= trial;
          quo_r <= {quo_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[DEN_W-1:0], quo_r[NUM_W-1]};
          quo_r <= {quo_r[NUM_W-2:0], 1'b0};
        end
      end
      if (cmd.tof) begin
        if (bad_r) begin
          tmag_r <= '0;
          neg_r <= 1'b0;
        end else if (neg_r) begin
          if (quo_r > NUM_W'(64'h80_0000_0000)) tmag_r <= 40'h80_0000_0000;
          else tmag_r <= quo_r[TOF_W-1:0];
          if (quo_r == '0) neg_r <= 1'b0;
        end else begin
          if (quo_r > NUM_W'(64'h7F_FFFF_FFFF)) tmag_r <= 40'h7F_FFFF_FFFF;
          else tmag_r <= quo_r[TOF_W-1:0];
        end
      end
      if (cmd.mul_hi) phi_r <= 40'(tmag_r) * 16'(mpt[31:16]);
      if (cmd.mul_lo) begin
        if (neg_r) dmag_r <= (dsum > (TOF_W+17)'(48'h8000_0000_0000)) ?
                              48'h8000_0000_0000 : DIST_W'(dsum);
        else dmag_r <= (dsum > (TOF_W+17)'(48'h7FFF_FFFF_FFFF)) ?
                       48'h7FFF_FFFF_FFFF : DIST_W'(dsum);
      end
      if (cmd.filt) begin
        rejected_r <= 1'b0;
        cleared_r <= 1'b0;
        need_mean_r <= 1'b1;
        // raw_r is formed combinationally from dmag_r, registered in the mul_lo step (see below)
        if (fill_r < FILL_W'(WINDOW_SIZE)) begin
          win_r[tail_idx] <= raw_r;
          fill_r <= fill_r + FILL_W'(1);
          total_r <= tot_acc;
          mdiv_r <= fill_r + FILL_W'(1);
        end else if (amag < (DIST_W+1)'(thr)) begin
          rej_r <= '0;
          win_r[head_r] <= raw_r;
          head_r <= (head_r == IDX_W'(WINDOW_SIZE - 1)) ? '0 : head_r + IDX_W'(1);
          total_r <= tot_acc - SUM_W'(win_r[head_r]);
          last_r <= raw_r;
          mdiv_r <= FILL_W'(WINDOW_SIZE);
        end else begin
          rejected_r <= 1'b1;
          need_mean_r <= 1'b0;
          if ((rej_r + LIM_W'(1)) > lim) begin
            rej_r <= '0;
            fill_r <= '0;
            head_r <= '0;
            total_r <= '0;
            cleared_r <= 1'b1;
          end else begin
            rej_r <= rej_r + LIM_W'(1);
          end
        end
      end
      if (cmd.mdiv_init) begin
        mneg_r <= total_r[SUM_W-1];
        mq_r <= total_r[SUM_W-1] ? SUM_W'(0) - total_r : total_r;
        mrem_r <= '0;
      end
      if (cmd.mdiv_step) begin
        if (!mtrial[FILL_W]) begin
          mrem_r <= mtrial;
          mq_r <= {mq_r[SUM_W-2:0], 1'b1};
        end else begin
          mrem_r <= {mrem_r[FILL_W-1:0], mq_r[SUM_W-1]};
          mq_r <= {mq_r[SUM_W-2:0], 1'b0};
        end
      end
      if (cmd.fin) begin
        flight_ticks <= neg_r ? TOF_W'(0) - tmag_r : tmag_r;
        raw_distance <= raw_r;
        if (need_mean_r)
          smoothed_distance <= mneg_r ? DIST_W'(SUM_W'(0) - mq_r) : DIST_W'(mq_r);
        else
          smoothed_distance <= last_r;
        sample_rejected <= rejected_r;
        window_cleared <= cleared_r;
        window_count <= CNT_W'(fill_r);
        bad_denominator <= bad_r;
      end
    end
  end

  // signed distance follows magnitude; valid from the filter step on
  always_comb raw_r = (neg_r && dmag_r != '0) ? DIST_W'(0) - dmag_r : dmag_r;
endmodule

// ----- rtl/ds_twr_range_filter_core.sv -----
// Top level: double-sided two-way ranging with windowed outlier filter
// The result item is formed with a 64-step restoring divider for the flight
// time and a 52-step divider for the window mean, which a rejected sample
// skips. No new item is taken until the result has been delivered and the
// block has returned to idle, which an output stall delays. The user must write
// config only while idle; the block itself does not enforce it.
`timescale 1ns / 1ps
module ds_twr_range_filter_core #(
  parameter int WINDOW_SIZE = dtrf_pkg::WINDOW_SIZE_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [dtrf_pkg::TS_W-1:0] in_remote_poll_sent,
  input  logic [dtrf_pkg::TS_W-1:0] in_remote_reply_heard,
  input  logic [dtrf_pkg::TS_W-1:0] in_remote_final_sent,
  input  logic [dtrf_pkg::TS_W-1:0] in_local_poll_heard,
  input  logic [dtrf_pkg::TS_W-1:0] in_local_reply_sent,
  input  logic [dtrf_pkg::TS_W-1:0] in_local_final_heard,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [dtrf_pkg::TOF_W-1:0] out_flight_ticks,
  output logic signed [dtrf_pkg::DIST_W-1:0] out_raw_distance,
  output logic signed [dtrf_pkg::DIST_W-1:0] out_smoothed_distance,
  output logic out_sample_rejected,
  output logic out_window_cleared,
  output logic [dtrf_pkg::CNT_W-1:0] out_window_count,
  output logic out_bad_denominator,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [dtrf_pkg::THR_W-1:0] cfg_data
);
  import dtrf_pkg::*;
  dtrf_cmd_t cmd;
  dtrf_sts_t sts;
  logic [TS_W-1:0] mpt_r;
  logic [THR_W-1:0] thr_r;
  logic [LIM_W-1:0] lim_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mpt_r <= MPT_RST;
      thr_r <= THR_RST;
      lim_r <= LIM_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MPT: mpt_r <= cfg_data[TS_W-1:0];
        REG_THR: thr_r <= cfg_data;
        REG_LIM: lim_r <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  dtrf_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  dtrf_datapath #(.WINDOW_SIZE(WINDOW_SIZE)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .ps(in_remote_poll_sent), .rh(in_remote_reply_heard), .fs(in_remote_final_sent),
    .ph(in_local_poll_heard), .rs(in_local_reply_sent), .fh(in_local_final_heard),
    .mpt(mpt_r), .thr(thr_r), .lim(lim_r),
    .flight_ticks(out_flight_ticks), .raw_distance(out_raw_distance),
    .smoothed_distance(out_smoothed_distance), .sample_rejected(out_sample_rejected),
    .window_cleared(out_window_cleared), .window_count(out_window_count),
    .bad_denominator(out_bad_denominator)
  );
endmodule

// ----- rtl/dtrf_checker.sv -----
// Port-level checker for the ranging core, bound to the top level
`timescale 1ns / 1ps
`include "ds_twr_range_filter_core_macros.svh"
module dtrf_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_sample_rejected,
  input logic out_window_cleared,
  input logic out_bad_denominator,
  input logic signed [39:0] out_flight_ticks,
  input logic [3:0] out_window_count
);
  `DTRF_ASSERT_IMP(a_busy_while_out, out_valid, in_stall)
  `DTRF_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
  `DTRF_ASSERT_IMP(a_clear_is_reject, out_valid && out_window_cleared, out_sample_rejected)
  `DTRF_ASSERT_IMP(a_clear_empty, out_valid && out_window_cleared, out_window_count == 4'd0)
  `DTRF_ASSERT_IMP(a_bad_zero, out_valid && out_bad_denominator, out_flight_ticks == 40'sd0)
endmodule

bind ds_twr_range_filter_core dtrf_checker u_dtrf_checker (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
  .out_sample_rejected, .out_window_cleared, .out_bad_denominator,
  .out_flight_ticks, .out_window_count
);
